// ===== src/affine_warp_coordinate_generator_unit_assert.svh =====
// Assertion macros for the files that check their own logic.
`ifndef AFFINE_WARP_COORDINATE_GENERATOR_UNIT_ASSERT_SVH
`define AFFINE_WARP_COORDINATE_GENERATOR_UNIT_ASSERT_SVH

`ifndef SYNTH
`define AWCG_ASSERT_SAME(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("awcg check failed");
`define AWCG_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("awcg check failed");
`else
`define AWCG_ASSERT_SAME(label, clk, rst, ante, cons)
`define AWCG_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== src/awcg_pkg.sv =====
package awcg_pkg;

  localparam int COEF_W   = 32;
  localparam int COORD_W  = 12;
  localparam int SOURCE_W = 16;
  localparam int WIDX_W   = 10;
  localparam int CFG_IDX_W = 3;
  localparam int NSTAGE   = 5;

  localparam logic signed [COEF_W-1:0] UNIT_COEF = 32'sd65536;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_COEF_XX  = 3'd0,
    REG_COEF_XY  = 3'd1,
    REG_OFFSET_X = 3'd2,
    REG_COEF_YX  = 3'd3,
    REG_COEF_YY  = 3'd4,
    REG_OFFSET_Y = 3'd5
  } reg_index_t;

  typedef struct packed {
    logic signed [COEF_W-1:0] coef_xx;
    logic signed [COEF_W-1:0] coef_xy;
    logic signed [COEF_W-1:0] offset_x;
    logic signed [COEF_W-1:0] coef_yx;
    logic signed [COEF_W-1:0] coef_yy;
    logic signed [COEF_W-1:0] offset_y;
  } matrix_t;

  typedef struct packed {
    logic [NSTAGE:1] load;
    logic [NSTAGE:1] valid;
  } stage_ctrl_t;

endpackage

// ===== src/awcg_in_if.sv =====
interface awcg_in_if;
  logic                         valid;
  logic                         ready;
  logic [awcg_pkg::COORD_W-1:0] dest_col;
  logic [awcg_pkg::COORD_W-1:0] dest_row;

  modport source (output valid, dest_col, dest_row, input ready);
  modport sink (input valid, dest_col, dest_row, output ready);
endinterface

// ===== src/awcg_out_if.sv =====
interface awcg_out_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [awcg_pkg::SOURCE_W-1:0] source_col;
  logic signed [awcg_pkg::SOURCE_W-1:0] source_row;
  logic [awcg_pkg::WIDX_W-1:0]          weight_index;

  modport source (output valid, source_col, source_row, weight_index, input ready);
  modport sink (input valid, source_col, source_row, weight_index, output ready);
endinterface

// ===== src/awcg_cfg_if.sv =====
interface awcg_cfg_if;
  logic                           valid;
  logic                           ready;
  logic [awcg_pkg::CFG_IDX_W-1:0] index;
  logic [awcg_pkg::COEF_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== src/awcg_regs.sv =====
module awcg_regs (
  input  logic              clk,
  input  logic              rst,
  awcg_cfg_if.sink          cfg,
  output awcg_pkg::matrix_t matrix
);

  assign cfg.ready = 1'b1;

  // Writes to an index past the last register are dropped.
  always_ff @(posedge clk) begin
    if (rst) begin
      matrix.coef_xx  <= awcg_pkg::UNIT_COEF;
      matrix.coef_xy  <= '0;
      matrix.offset_x <= '0;
      matrix.coef_yx  <= '0;
      matrix.coef_yy  <= awcg_pkg::UNIT_COEF;
      matrix.offset_y <= '0;
    end else if (cfg.valid) begin
      unique case (awcg_pkg::reg_index_t'(cfg.index))
        awcg_pkg::REG_COEF_XX:  matrix.coef_xx  <= cfg.data;
        awcg_pkg::REG_COEF_XY:  matrix.coef_xy  <= cfg.data;
        awcg_pkg::REG_OFFSET_X: matrix.offset_x <= cfg.data;
        awcg_pkg::REG_COEF_YX:  matrix.coef_yx  <= cfg.data;
        awcg_pkg::REG_COEF_YY:  matrix.coef_yy  <= cfg.data;
        awcg_pkg::REG_OFFSET_Y: matrix.offset_y <= cfg.data;
        default: ;
      endcase
    end
  end

endmodule

// ===== src/awcg_pipe_ctrl.sv =====
module awcg_pipe_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  input  logic                  out_ready,
  output logic                  in_ready,
  output logic                  out_valid,
  output awcg_pkg::stage_ctrl_t ctrl
);

  localparam int N = awcg_pkg::NSTAGE;

  logic [N:1]   valid;
  logic [N+1:1] load;

  // A stage takes new data when it is empty or its contents move on.
  always_comb begin
    load[N+1] = out_ready;
    for (int k = N; k >= 1; k--) begin
      load[k] = !valid[k] || load[k+1];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (load[1]) begin
        valid[1] <= in_valid;
      end
      for (int k = 2; k <= N; k++) begin
        if (load[k]) begin
          valid[k] <= valid[k-1];
        end
      end
    end
  end

  assign ctrl.load  = load[N:1];
  assign ctrl.valid = valid;
  assign in_ready   = load[1];
  assign out_valid  = valid[N];

endmodule

// ===== src/awcg_axis.sv =====
module awcg_axis #(
  parameter int FRAC_BITS = 5,
  parameter int COEF_FRAC = 16
) (
  input  logic                                 clk,
  input  awcg_pkg::stage_ctrl_t                ctrl,
  input  logic signed [awcg_pkg::COEF_W-1:0]   coef_col,
  input  logic signed [awcg_pkg::COEF_W-1:0]   coef_row,
  input  logic signed [awcg_pkg::COEF_W-1:0]   offset,
  input  logic [awcg_pkg::COORD_W-1:0]         col,
  input  logic [awcg_pkg::COORD_W-1:0]         row,
  output logic signed [awcg_pkg::SOURCE_W-1:0] whole,
  output logic [FRAC_BITS-1:0]                 frac
);

  localparam int PW    = awcg_pkg::COEF_W + awcg_pkg::COORD_W + 1;
  localparam int TWO_F = 2 * FRAC_BITS;
  localparam int RW    = PW + 2 + TWO_F;
  localparam logic signed [RW-1:0] RND  = RW'(1) <<< (COEF_FRAC - 1);
  localparam logic signed [RW-1:0] HALF = RW'(1) <<< (FRAC_BITS - 1);

  logic signed [PW-1:0] prod_col, prod_row;
  logic signed [RW-1:0] ext_col, ext_row, rnd_col, rnd_row;
  logic signed [RW-1:0] term_col, term_row, grid_sum, grid, corner;

  // Stage 2: the two products.
  always_ff @(posedge clk) begin
    if (ctrl.load[2]) begin
      prod_col <= coef_col * signed'({1'b0, col});
      prod_row <= coef_row * signed'({1'b0, row});
    end
  end

  // Stage 3: each term is rescaled to 2*FRAC_BITS fraction bits and rounded half up on its own.
  assign ext_col = RW'(prod_col);
  assign ext_row = RW'(prod_row) + RW'(offset);
  assign rnd_col = (ext_col <<< TWO_F) + RND;
  assign rnd_row = (ext_row <<< TWO_F) + RND;

  always_ff @(posedge clk) begin
    if (ctrl.load[3]) begin
      term_col <= rnd_col >>> COEF_FRAC;
      term_row <= rnd_row >>> COEF_FRAC;
    end
  end

  // Stage 4: grid coordinate in 1/2^FRAC_BITS pixel steps.
  assign grid_sum = term_col + term_row + HALF;

  always_ff @(posedge clk) begin
    if (ctrl.load[4]) begin
      grid <= grid_sum >>> FRAC_BITS;
    end
  end

  assign corner = grid >>> FRAC_BITS;
  assign whole  = corner[awcg_pkg::SOURCE_W-1:0];
  assign frac   = grid[FRAC_BITS-1:0];

endmodule

// ===== src/affine_warp_coordinate_generator_unit.sv =====
// Affine warp coordinate generator. Each destination pixel request on dest
// is mapped through the 2x3 Q16 matrix in the six configuration registers
// and yields one result: the top-left integer source pixel (wrapped to 16
// bits) and the bilinear weight index, fractional row times 2^FRAC_BITS
// plus fractional column. The block takes one request per clock while
// result does not stall. Each request passes through five register stages
// (input capture, which loads at the accepting edge, the four 32x13
// products, per-term rounding, grid sum, output register) before its
// result is offered. A stall on result holds the pipeline without losing
// or repeating a request.
// Write the registers only while no request is in flight.
`include "affine_warp_coordinate_generator_unit_assert.svh"

module affine_warp_coordinate_generator_unit #(
  parameter int FRAC_BITS = 5,
  parameter int COEF_FRAC = 16
) (
  input logic        clk,
  input logic        rst,
  awcg_in_if.sink    dest,
  awcg_out_if.source result,
  awcg_cfg_if.sink   cfg
);

  awcg_pkg::matrix_t                   matrix;
  awcg_pkg::stage_ctrl_t               ctrl;
  logic [awcg_pkg::COORD_W-1:0]        col, row;
  logic signed [awcg_pkg::SOURCE_W-1:0] whole_x, whole_y;
  logic [FRAC_BITS-1:0]                frac_x, frac_y;
  logic [2*FRAC_BITS-1:0]              index_full;

  awcg_regs u_regs (
    .clk    (clk),
    .rst    (rst),
    .cfg    (cfg),
    .matrix (matrix)
  );

  awcg_pipe_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (dest.valid),
    .out_ready (result.ready),
    .in_ready  (dest.ready),
    .out_valid (result.valid),
    .ctrl      (ctrl)
  );

  always_ff @(posedge clk) begin
    if (ctrl.load[1]) begin
      col <= dest.dest_col;
      row <= dest.dest_row;
    end
  end

  awcg_axis #(
    .FRAC_BITS (FRAC_BITS),
    .COEF_FRAC (COEF_FRAC)
  ) u_axis_x (
    .clk      (clk),
    .ctrl     (ctrl),
    .coef_col (matrix.coef_xx),
    .coef_row (matrix.coef_xy),
    .offset   (matrix.offset_x),
    .col      (col),
    .row      (row),
    .whole    (whole_x),
    .frac     (frac_x)
  );

  awcg_axis #(
    .FRAC_BITS (FRAC_BITS),
    .COEF_FRAC (COEF_FRAC)
  ) u_axis_y (
    .clk      (clk),
    .ctrl     (ctrl),
    .coef_col (matrix.coef_yx),
    .coef_row (matrix.coef_yy),
    .offset   (matrix.offset_y),
    .col      (col),
    .row      (row),
    .whole    (whole_y),
    .frac     (frac_y)
  );

  assign index_full = {frac_y, frac_x};

  always_ff @(posedge clk) begin
    if (ctrl.load[awcg_pkg::NSTAGE]) begin
      result.source_col   <= whole_x;
      result.source_row   <= whole_y;
      result.weight_index <= awcg_pkg::WIDX_W'(index_full);
    end
  end

  // An accepting consumer leaves every stage free to move.
  `AWCG_ASSERT_SAME(a_ready_chain, clk, rst, result.ready, dest.ready)
  // A request in the capture stage reaches the product stage when that stage loads.
  `AWCG_ASSERT_NEXT(a_stage_move, clk, rst, ctrl.valid[1] && ctrl.load[2], ctrl.valid[2])
  // No result is offered in the cycle after reset.
  `AWCG_ASSERT_SAME(a_reset_empty, clk, rst, $fell(rst), !result.valid)

endmodule
